// ----- hw/rtl/cltw_pkg.sv -----
// ----------------------------------------------------------------------------
// cltw_pkg: shared types and constants for the character LCD text writer
// Item modes, register indexes, control characters and address helpers.
// ----------------------------------------------------------------------------
package cltw_pkg;

  // item modes as carried in the input word
  typedef enum logic [1:0] {
    MODE_POS  = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_RAW  = 2'd2
  } mode_e;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [5:0] COLUMNS_RESET = 6'd16;
  localparam logic [2:0] ROWS_RESET    = 3'd2;

  // controller constants
  localparam logic [7:0] ADDR_CMD = 8'h80;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one queued work entry: one or two bytes to send as nibbles
  typedef struct packed {
    logic       two;
    logic       rs0;
    logic [7:0] b0;
    logic       rs1;
    logic [7:0] b1;
  } entry_t;

  // DDRAM base address per display row
  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // row falls back to 0 when beyond the rows in use
  function automatic logic [1:0] row_fix(input logic [1:0] r, input logic [2:0] rows);
    return ({1'b0, r} >= rows) ? 2'd0 : r;
  endfunction

  // set-address command, kept to 8 bits
  function automatic logic [7:0] addr_cmd(input logic [5:0] c, input logic [1:0] r);
    return ADDR_CMD | ({2'b00, c} + row_base(r));
  endfunction

endpackage

// ----- hw/rtl/cltw_queue.sv -----
// ----------------------------------------------------------------------------
// cltw_queue: small work queue between front and back
// Register-based FIFO of work entries with full and valid flags.
// ----------------------------------------------------------------------------
module cltw_queue #(
  parameter int unsigned Depth = cltw_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cltw_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output cltw_pkg::entry_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  cltw_pkg::entry_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o       = (cnt_q == FULL_CNT);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/cltw_front.sv -----
// ----------------------------------------------------------------------------
// cltw_front: item decode and cursor tracking
// Accepts items, updates the cursor and queues the bytes each item causes.
// ----------------------------------------------------------------------------
module cltw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_valid_i,
  input  logic             cfg_index_i,
  input  logic [5:0]       cfg_data_i,
  // items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [5:0]       col_i,
  input  logic [1:0]       row_i,
  input  logic [7:0]       char_i,
  // queue side
  input  logic             queue_full_i,
  output logic             push_o,
  output cltw_pkg::entry_t entry_o
);

  logic [5:0] columns_q;
  logic [2:0] rows_q;
  logic [5:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic       emit;
  logic       accept;

  // state after an optional line wrap
  logic       wrap;
  logic [5:0] col_w;
  logic [1:0] row_w;
  logic [1:0] row_t;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emit;

  // decode and cursor update
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    emit    = 1'b0;
    entry_o = '0;
    wrap    = (col_q >= columns_q);
    col_w   = wrap ? 6'd0 : col_q;
    row_w   = wrap ? cltw_pkg::row_fix(row_q + 2'd1, rows_q) : row_q;
    row_t   = cltw_pkg::row_fix(row_i, rows_q);
    case (mode_i)
      cltw_pkg::MODE_POS: begin
        emit        = 1'b1;
        col_d       = col_i;
        row_d       = row_t;
        entry_o.rs0 = cltw_pkg::RS_CMD;
        entry_o.b0  = cltw_pkg::addr_cmd(col_i, row_t);
      end
      cltw_pkg::MODE_TEXT: begin
        if (char_i != cltw_pkg::CH_NUL) begin
          emit = 1'b1;
          // second byte: the character's own action
          if (char_i == cltw_pkg::CH_NL) begin
            col_d       = col_w;
            row_d       = cltw_pkg::row_fix(row_w + 2'd1, rows_q);
            entry_o.rs1 = cltw_pkg::RS_CMD;
            entry_o.b1  = cltw_pkg::addr_cmd(col_d, row_d);
          end else if (char_i == cltw_pkg::CH_CR) begin
            // current row may lie beyond a smaller row count
            col_d       = 6'd0;
            row_d       = cltw_pkg::row_fix(row_w, rows_q);
            entry_o.rs1 = cltw_pkg::RS_CMD;
            entry_o.b1  = cltw_pkg::addr_cmd(6'd0, row_d);
          end else begin
            col_d       = col_w + 6'd1;
            row_d       = row_w;
            entry_o.rs1 = cltw_pkg::RS_DATA;
            entry_o.b1  = char_i;
          end
          // wrap command goes first, otherwise shift action into slot 0
          if (wrap) begin
            entry_o.two = 1'b1;
            entry_o.rs0 = cltw_pkg::RS_CMD;
            entry_o.b0  = cltw_pkg::addr_cmd(6'd0, row_w);
          end else begin
            entry_o.rs0 = entry_o.rs1;
            entry_o.b0  = entry_o.b1;
          end
        end
      end
      cltw_pkg::MODE_RAW: begin
        emit        = 1'b1;
        entry_o.rs0 = cltw_pkg::RS_DATA;
        entry_o.b0  = char_i;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // cursor and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      columns_q <= cltw_pkg::COLUMNS_RESET;
      rows_q    <= cltw_pkg::ROWS_RESET;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == cltw_pkg::CFG_COLUMNS) begin
          columns_q <= cfg_data_i;
        end else begin
          rows_q <= cfg_data_i[2:0];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/cltw_back.sv -----
// ----------------------------------------------------------------------------
// cltw_back: nibble sequencer
// Splits queued bytes into nibbles, high first, into an output register.
// ----------------------------------------------------------------------------
module cltw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  cltw_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_rs_o,
  output logic [3:0]       out_nibble_o,
  output logic             out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic       rs_q, last_q;
  logic [3:0] nib_q;
  logic       load;
  logic       cur_rs, cur_last;
  logic [7:0] cur_byte;
  logic [3:0] cur_nib;

  // current nibble selection
  always_comb begin
    cur_rs   = idx_q[1] ? head_i.rs1 : head_i.rs0;
    cur_byte = idx_q[1] ? head_i.b1 : head_i.b0;
    cur_nib  = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
    cur_last = idx_q[0] && (idx_q[1] || !head_i.two);
  end

  assign load  = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load && cur_last;

  // sequencer and output valid
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = cur_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q   <= cur_rs;
      nib_q  <= cur_nib;
      last_q <= cur_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_rs_o     = rs_q;
  assign out_nibble_o = nib_q;
  assign out_last_o   = last_q;

endmodule

// ----- hw/rtl/char_lcd_text_writer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_text_writer: text stream to 4-bit character LCD bus words
// Tracks the cursor and emits command and data nibbles, high nibble first.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Contents
// s_axis    in   s_axis_tvalid/tready   text item word
// m_axis    out  m_axis_tvalid/tready   one nibble word, tlast ends the item
// cfg       in   cfg_valid_i/cfg_ready_o register index and value
//
// An item yields 0 to 4 nibble words.
// The back end emits one nibble word per cycle while m_axis_tready is high and
// the work queue holds an entry.
// The front keeps taking items while the work queue has room; a stalled
// output fills the queue and then holds s_axis_tready low.
// Reset clears the cursor to column 0, row 0, sets columns 16 and rows 2.
// ----------------------------------------------------------------------------
module char_lcd_text_writer #(
  parameter int unsigned QueueDepth = cltw_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // mode[1:0], col[7:2], row[9:8], char_code[17:10]
  // output nibbles
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // nibble[3:0]
  output logic        m_axis_tuser,  // reg_select[0]
  output logic        m_axis_tlast
);

  logic             push, pop, full, head_valid;
  cltw_pkg::entry_t entry, head;
  logic [3:0]       nibble;

  assign cfg_ready_o = 1'b1;

  cltw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tdata[1:0]),
    .col_i        (s_axis_tdata[7:2]),
    .row_i        (s_axis_tdata[9:8]),
    .char_i       (s_axis_tdata[17:10]),
    .queue_full_i (full),
    .push_o       (push),
    .entry_o      (entry)
  );

  cltw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cltw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (m_axis_tuser),
    .out_nibble_o (nibble),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, nibble};

endmodule
